FILE: hw/rtl/gg_pkg.sv
package gg_pkg;

  localparam int TABLE_DEPTH_DEF = 8;

  localparam logic [7:0]  OWN_ID_RESET = 8'd0;
  localparam logic [16:0] LIMIT_RESET  = 17'd32000;

  // register index as decoded from paddr[2]
  localparam logic REG_OWN_ID = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  typedef enum logic [2:0] {
    ACT_DELIVER = 3'd0,
    ACT_FORWARD = 3'd1,
    ACT_NOROUTE = 3'd2,
    ACT_ADDED   = 3'd3,
    ACT_IGNORED = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] x;
    logic [7:0] y;
  } entry_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic [7:0]  id;
    logic [16:0] sq_dist;
  } dist_res_t;

  typedef struct packed {
    logic       func;
    logic [7:0] beacon_id;
    logic [7:0] beacon_x;
    logic [7:0] beacon_y;
    logic [7:0] dest_x;
    logic [7:0] dest_y;
    logic [7:0] source_id;
    logic [7:0] target_id;
  } item_t;

  typedef struct packed {
    act_t        action;
    logic [7:0]  next_hop;
    logic [15:0] delivered_total;
    logic [15:0] local_forward_total;
    logic [15:0] remote_forward_total;
  } result_t;

  typedef struct packed {
    logic [7:0]  own_id;
    logic [16:0] distance_limit;
  } cfg_t;

endpackage

FILE: hw/rtl/greedy_geo_forwarder.sv
// Channel   Dir  tdata fields (low bit up)                            tuser
// s_*       in   beacon_id, beacon_x, beacon_y, dest_x, dest_y,        func
//                source_id, target_id (56 bits)
// m_*       out  next_hop, delivered_total, local_forward_total,       action
//                remote_forward_total (56 bits)
// APB       in   0x0 own_id (8 bits), 0x4 distance_limit (17 bits)
//
// One item at a time. Local delivery, or any item with an empty table, goes
// from idle straight to the final state, which loads the output register;
// otherwise the item passes n table reads for n stored neighbours, the
// distance stage, a drain state and the final state.
// Table writes happen only in the final cycle, after all reads of the item.
// Reset (rst, synchronous) empties the table and clears the counters.
// A result waiting on m_tready holds the block in its final cycle.
module greedy_geo_forwarder import gg_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // beacon_id, beacon_x, beacon_y, dest_x, dest_y,
                                // source_id, target_id
  input  logic        s_tuser,  // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // next_hop, delivered_total, local_forward_total,
                                // remote_forward_total
  output logic [2:0]  m_tuser,  // action
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(TABLE_DEPTH);

  cfg_t          cfg;
  item_t         s_item;
  result_t       m_res;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          p1_valid;
  logic          p1_last;
  logic [7:0]    dest_x;
  logic [7:0]    dest_y;
  dist_res_t     dres;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_id         <= OWN_ID_RESET;
      cfg.distance_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_OWN_ID: cfg.own_id         <= pwdata[7:0];
        REG_LIMIT:  cfg.distance_limit <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OWN_ID: prdata = {24'd0, cfg.own_id};
      REG_LIMIT:  prdata = {15'd0, cfg.distance_limit};
      default:    prdata = 32'd0;
    endcase
  end

  assign s_item.func      = s_tuser;
  assign s_item.beacon_id = s_tdata[7:0];
  assign s_item.beacon_x  = s_tdata[15:8];
  assign s_item.beacon_y  = s_tdata[23:16];
  assign s_item.dest_x    = s_tdata[31:24];
  assign s_item.dest_y    = s_tdata[39:32];
  assign s_item.source_id = s_tdata[47:40];
  assign s_item.target_id = s_tdata[55:48];

  assign m_tuser = m_res.action;
  assign m_tdata = {m_res.remote_forward_total, m_res.local_forward_total,
                    m_res.delivered_total, m_res.next_hop};

  gg_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_valid  (s_tvalid),
    .s_ready  (s_tready),
    .s_item   (s_item),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_res    (m_res),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .p1_valid (p1_valid),
    .p1_last  (p1_last),
    .dest_x   (dest_x),
    .dest_y   (dest_y),
    .dres     (dres)
  );

  gg_table #(.DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  gg_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (p1_valid),
    .in_last  (p1_last),
    .entry    (rd_data),
    .dest_x   (dest_x),
    .dest_y   (dest_y),
    .res      (dres)
  );

endmodule

FILE: hw/rtl/gg_table.sv
module gg_table import gg_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/gg_dist.sv
module gg_dist import gg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_last,
  input  entry_t     entry,
  input  logic [7:0] dest_x,
  input  logic [7:0] dest_y,
  output dist_res_t  res
);

  logic [7:0]  ax;
  logic [7:0]  ay;
  logic [15:0] sx;
  logic [15:0] sy;

  always_comb begin
    ax = (entry.x > dest_x) ? (entry.x - dest_x) : (dest_x - entry.x);
    ay = (entry.y > dest_y) ? (entry.y - dest_y) : (dest_y - entry.y);
    sx = {8'd0, ax} * {8'd0, ax};
    sy = {8'd0, ay} * {8'd0, ay};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= in_valid;
    end
    res.last <= in_last;
    res.id   <= entry.id;
    // full 17-bit sum, max 2*255^2
    res.sq_dist <= {1'b0, sx} + {1'b0, sy};
  end

endmodule

FILE: hw/rtl/gg_ctrl.sv
module gg_ctrl import gg_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          s_valid,
  output logic          s_ready,
  input  item_t         s_item,
  output logic          m_valid,
  input  logic          m_ready,
  output result_t       m_res,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output entry_t        wr_data,
  output logic          p1_valid,
  output logic          p1_last,
  output logic [7:0]    dest_x,
  output logic [7:0]    dest_y,
  input  dist_res_t     dres
);

  state_t      state;
  state_t      state_next;
  item_t       item;
  logic [AW-1:0] rd_idx;
  logic [CW-1:0] count;
  logic [16:0] best;
  logic [7:0]  hop;
  logic        found;
  logic        dup;
  logic [15:0] delivered;
  logic [15:0] local_fwd;
  logic [15:0] remote_fwd;

  logic        accept;
  logic        rd_last;
  logic        fin_go;
  logic        is_local;
  logic        adjacent;
  logic        full;
  logic        add;
  result_t     res_next;

  assign accept   = s_valid && s_ready;
  assign rd_last  = (CW'(rd_idx) == (count - CW'(1)));
  assign is_local = item.func && (item.target_id == cfg.own_id);
  // no wrap at either end of the id range
  assign adjacent = ({1'b0, item.beacon_id} == ({1'b0, cfg.own_id} + 9'd1)) ||
                    (({1'b0, item.beacon_id} + 9'd1) == {1'b0, cfg.own_id});
  assign full     = (count == CW'(DEPTH));
  assign add      = !item.func && !dup && adjacent && !full;

  assign rd_addr  = rd_idx;
  assign dest_x   = item.dest_x;
  assign dest_y   = item.dest_y;
  assign wr_en    = fin_go && add;
  assign wr_addr  = count[AW-1:0];
  assign wr_data  = '{id: item.beacon_id, x: item.beacon_x, y: item.beacon_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_ready    = 1'b0;
    rd_en      = 1'b0;
    fin_go     = 1'b0;
    case (state)
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          if ((s_item.func && (s_item.target_id == cfg.own_id)) || (count == '0)) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (rd_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dres.valid && dres.last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold the result until the output register is free
        if (!m_valid || m_ready) begin
          fin_go     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_next.action               = ACT_IGNORED;
    res_next.next_hop             = 8'd0;
    res_next.delivered_total      = delivered;
    res_next.local_forward_total  = local_fwd;
    res_next.remote_forward_total = remote_fwd;
    if (!item.func) begin
      res_next.action = add ? ACT_ADDED : ACT_IGNORED;
    end else if (is_local) begin
      res_next.action          = ACT_DELIVER;
      res_next.delivered_total = delivered + 16'd1;
    end else if (found) begin
      res_next.action   = ACT_FORWARD;
      res_next.next_hop = hop;
      if (item.source_id == cfg.own_id) begin
        res_next.local_forward_total = local_fwd + 16'd1;
      end else begin
        res_next.remote_forward_total = remote_fwd + 16'd1;
      end
    end else begin
      res_next.action = ACT_NOROUTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      delivered  <= '0;
      local_fwd  <= '0;
      remote_fwd <= '0;
      m_valid    <= 1'b0;
      p1_valid   <= 1'b0;
    end else begin
      p1_valid <= rd_en;
      if (fin_go) begin
        m_valid    <= 1'b1;
        delivered  <= res_next.delivered_total;
        local_fwd  <= res_next.local_forward_total;
        remote_fwd <= res_next.remote_forward_total;
        if (add) begin
          count <= count + CW'(1);
        end
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_last <= rd_en && rd_last;
    if (fin_go) begin
      m_res <= res_next;
    end
    if (accept) begin
      item   <= s_item;
      best   <= cfg.distance_limit;
      hop    <= 8'd0;
      found  <= 1'b0;
      dup    <= 1'b0;
      rd_idx <= '0;
    end else begin
      if (rd_en) begin
        rd_idx <= rd_idx + AW'(1);
      end
      if (dres.valid) begin
        if (dres.id == item.beacon_id) begin
          dup <= 1'b1;
        end
        // strict compare keeps the earliest entry on a tie
        if (dres.sq_dist < best) begin
          best  <= dres.sq_dist;
          hop   <= dres.id;
          found <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/gg_checker.sv
module gg_checker import gg_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // next hop is zero unless forwarding
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ACT_FORWARD) |-> (m_tdata[7:0] == 8'd0))
    else $error("next hop set on a non-forward result");

  // one item in work at a time
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind greedy_geo_forwarder gg_checker u_checker (.*);

FILE: bench/greedy_geo_forwarder_checker.sv
`timescale 1ns / 1ps

module greedy_geo_forwarder_checker import gg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,  // beacon_id, beacon_x, beacon_y, dest_x, dest_y,
                                // source_id, target_id
  input  logic        s_tuser,  // func
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,  // next_hop, delivered_total, local_forward_total,
                                // remote_forward_total
  input  logic [2:0]  m_tuser,  // action
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output int          forwarded,
  output logic        table_full
);

  localparam int DEPTH = TABLE_DEPTH_DEF;

  logic [7:0]  nb_id [DEPTH];
  logic [7:0]  nb_x [DEPTH];
  logic [7:0]  nb_y [DEPTH];
  logic        nb_valid [DEPTH];
  int          nb_count;
  logic [15:0] n_delivered;
  logic [15:0] n_local_fwd;
  logic [15:0] n_remote_fwd;
  logic [7:0]  my_id;
  logic [16:0] max_dist;
  result_t     route_q[$];

  assign table_full = (nb_count == DEPTH);

  function automatic int sq_gap(logic [7:0] a, logic [7:0] b);
    int d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  // Updates the neighbour table and counters, returns the routing decision.
  function automatic result_t route_item(item_t it);
    result_t r;
    logic    dup;
    logic    found;
    int      best;
    int      d;
    r.action   = ACT_IGNORED;
    r.next_hop = 8'd0;
    if (!it.func) begin
      dup = 1'b0;
      for (int i = 0; i < nb_count; i++)
        if (nb_valid[i] && nb_id[i] == it.beacon_id) dup = 1'b1;
      // ids are compared without wrap-around
      if (!dup && nb_count < DEPTH &&
          (int'(it.beacon_id) == int'(my_id) + 1 ||
           int'(it.beacon_id) + 1 == int'(my_id))) begin
        nb_id[nb_count]    = it.beacon_id;
        nb_x[nb_count]     = it.beacon_x;
        nb_y[nb_count]     = it.beacon_y;
        nb_valid[nb_count] = 1'b1;
        nb_count++;
        r.action = ACT_ADDED;
      end
    end else if (it.target_id == my_id) begin
      n_delivered = n_delivered + 16'd1;
      r.action = ACT_DELIVER;
    end else begin
      best  = max_dist;
      found = 1'b0;
      for (int i = 0; i < nb_count; i++) begin
        if (nb_valid[i]) begin
          d = sq_gap(nb_x[i], it.dest_x) + sq_gap(nb_y[i], it.dest_y);
          if (d < best) begin
            best       = d;
            r.next_hop = nb_id[i];
            found      = 1'b1;
          end
        end
      end
      if (found) begin
        if (it.source_id == my_id) n_local_fwd = n_local_fwd + 16'd1;
        else n_remote_fwd = n_remote_fwd + 16'd1;
        r.action = ACT_FORWARD;
      end else begin
        r.next_hop = 8'd0;
        r.action   = ACT_NOROUTE;
      end
    end
    r.delivered_total      = n_delivered;
    r.local_forward_total  = n_local_fwd;
    r.remote_forward_total = n_remote_fwd;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    item_t   it;
    result_t want;
    result_t seen;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) nb_valid[i] = 1'b0;
      nb_count     = 0;
      n_delivered  = '0;
      n_local_fwd  = '0;
      n_remote_fwd = '0;
      my_id        = OWN_ID_RESET;
      max_dist     = LIMIT_RESET;
      fail_count   = 0;
      checked      = 0;
      forwarded    = 0;
      route_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen.action               = act_t'(m_tuser);
        seen.next_hop             = m_tdata[7:0];
        seen.delivered_total      = m_tdata[23:8];
        seen.local_forward_total  = m_tdata[39:24];
        seen.remote_forward_total = m_tdata[55:40];
        if (route_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected, expected nothing, got action %0d hop %0d",
                   $time, seen.action, seen.next_hop);
        end else begin
          want = route_q.pop_front();
          checked++;
          check_field("action", want.action, seen.action);
          check_field("next_hop", want.next_hop, seen.next_hop);
          check_field("delivered_total", want.delivered_total, seen.delivered_total);
          check_field("local_forward_total", want.local_forward_total,
                      seen.local_forward_total);
          check_field("remote_forward_total", want.remote_forward_total,
                      seen.remote_forward_total);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_OWN_ID: my_id    = pwdata[7:0];
          REG_LIMIT:  max_dist = pwdata[16:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        it.func      = s_tuser;
        it.beacon_id = s_tdata[7:0];
        it.beacon_x  = s_tdata[15:8];
        it.beacon_y  = s_tdata[23:16];
        it.dest_x    = s_tdata[31:24];
        it.dest_y    = s_tdata[39:32];
        it.source_id = s_tdata[47:40];
        it.target_id = s_tdata[55:48];
        want = route_item(it);
        if (want.action == ACT_FORWARD) forwarded++;
        route_q.push_back(want);
      end
    end
    pending <= route_q.size();
  end

endmodule

FILE: bench/greedy_geo_forwarder_tb.sv
`timescale 1ns / 1ps

module greedy_geo_forwarder_tb;
  import gg_pkg::*;

  typedef enum {PACE_FREE, PACE_SEND, PACE_RECV, PACE_BOTH, PACE_HOLD} pace_t;

  localparam int SPARSE_PCT   = 79;
  localparam int SHARED_PCT   = 34;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASES       = 11;
  localparam int PHASE_ITEMS  = 76;
  localparam logic [2:0]  ADDR_OWN_ID = {REG_OWN_ID, 2'b00};
  localparam logic [2:0]  ADDR_LIMIT  = {REG_LIMIT, 2'b00};
  localparam logic [16:0] LIMIT_MAX   = 17'h1FFFF;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;  // beacon_id, beacon_x, beacon_y, dest_x, dest_y,
                              // source_id, target_id
  logic        s_tuser = 1'b0;  // func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;  // next_hop, delivered_total, local_forward_total,
                         // remote_forward_total
  logic [2:0]  m_tuser;  // action
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pace_t pace = PACE_FREE;
  int    hold_count = 0;
  int    cycles = 0;
  int    sent = 0;
  int    fail_count;
  int    pending;
  int    checked;
  int    forwarded;
  logic  table_full;
  logic [7:0] node_id;

  greedy_geo_forwarder dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  greedy_geo_forwarder_checker route_check (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending, .checked, .forwarded, .table_full
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
      $display("[greedy_geo_forwarder] ERROR");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off that backs the block up
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (pace == PACE_HOLD && hold_count < HOLD_CYCLES) begin
      m_tready   <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      case (pace)
        PACE_RECV: m_tready <= ($urandom_range(0, 99) >= SPARSE_PCT);
        PACE_BOTH: m_tready <= ($urandom_range(0, 99) >= SHARED_PCT);
        default:   m_tready <= 1'b1;
      endcase
    end
  end

  task automatic pause_sender();
    int n;
    n = 0;
    if (pace == PACE_SEND) while ($urandom_range(0, 99) < SPARSE_PCT) n++;
    if (pace == PACE_BOTH) while ($urandom_range(0, 99) < SHARED_PCT) n++;
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic offer(item_t it);
    s_tdata  <= {it.target_id, it.source_id, it.dest_y, it.dest_x,
                 it.beacon_y, it.beacon_x, it.beacon_id};
    s_tuser  <= it.func;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent++;
    pause_sender();
  endtask

  // stop offering and wait until every routing decision has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic item_t noise();
    item_t it;
    it.func      = 1'($urandom_range(0, 1));
    it.beacon_id = 8'($urandom_range(0, 255));
    it.beacon_x  = 8'($urandom_range(0, 255));
    it.beacon_y  = 8'($urandom_range(0, 255));
    it.dest_x    = 8'($urandom_range(0, 255));
    it.dest_y    = 8'($urandom_range(0, 255));
    it.source_id = 8'($urandom_range(0, 255));
    it.target_id = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic item_t beacon(logic [7:0] id, logic [7:0] x, logic [7:0] y);
    item_t it;
    it = noise();
    it.func      = 1'b0;
    it.beacon_id = id;
    it.beacon_x  = x;
    it.beacon_y  = y;
    return it;
  endfunction

  function automatic item_t packet(logic [7:0] x, logic [7:0] y,
                                   logic [7:0] src, logic [7:0] dst);
    item_t it;
    it = noise();
    it.func      = 1'b1;
    it.dest_x    = x;
    it.dest_y    = y;
    it.source_id = src;
    it.target_id = dst;
    return it;
  endfunction

  // coarse grid makes equal distances, and so ties, common
  function automatic logic [7:0] grid();
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd64;
      2:       return 8'd128;
      3:       return 8'd192;
      default: return 8'd255;
    endcase
  endfunction

  function automatic item_t rand_item(logic [7:0] own);
    item_t it;
    it = noise();
    it.func = ($urandom_range(0, 99) < 20) ? 1'b0 : 1'b1;
    if ($urandom_range(0, 1) == 1) begin
      it.beacon_x = grid();
      it.beacon_y = grid();
      it.dest_x   = grid();
      it.dest_y   = grid();
    end
    if ($urandom_range(0, 9) < 7)
      it.beacon_id = ($urandom_range(0, 1) == 1) ? own + 8'd1 : own - 8'd1;
    if ($urandom_range(0, 3) == 0) it.target_id = own;
    if ($urandom_range(0, 4) < 2) it.source_id = own;
    return it;
  endfunction

  // the first three ids sit apart so their neighbours are distinct table entries
  function automatic logic [7:0] pick_own(int p);
    case (p)
      0:       return 8'($urandom_range(10, 60));
      1:       return 8'($urandom_range(80, 140));
      2:       return 8'($urandom_range(160, 240));
      3:       return 8'd0;
      4:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [16:0] pick_limit(int p);
    if (p == 5) return 17'd0;
    case (p % 4)
      0:       return LIMIT_RESET;
      1:       return 17'($urandom_range(0, 131071));
      2:       return LIMIT_MAX;
      default: return 17'($urandom_range(500, 20000));
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults after reset: own id 0, limit 32000, empty table
    offer(packet(8'd17, 8'd200, 8'd0, 8'd0));
    offer(packet(8'd0, 8'd0, 8'd3, 8'd9));
    offer(beacon(8'd255, 8'd10, 8'd10));
    offer(beacon(8'd1, 8'd0, 8'd0));
    offer(beacon(8'd1, 8'd255, 8'd255));
    offer(packet(8'd0, 8'd0, 8'd0, 8'd7));
    offer(packet(8'd255, 8'd255, 8'd9, 8'd7));
    offer(packet(8'd100, 8'd100, 8'd3, 8'd7));
    offer(packet(8'd42, 8'd99, 8'd255, 8'd0));
    settle();
    // widest distance against the limit, either side of strictly below
    apb_write(ADDR_LIMIT, 32'(LIMIT_MAX));
    offer(packet(8'd255, 8'd255, 8'd3, 8'd7));
    settle();
    apb_write(ADDR_LIMIT, 32'd130050);
    offer(packet(8'd255, 8'd255, 8'd3, 8'd7));
    settle();
    apb_write(ADDR_OWN_ID, 32'd255);
    apb_write(ADDR_LIMIT, 32'(LIMIT_MAX));
    offer(beacon(8'd0, 8'd5, 8'd5));
    offer(beacon(8'd255, 8'd6, 8'd6));
    offer(beacon(8'd254, 8'd255, 8'd255));
    offer(packet(8'd128, 8'd127, 8'd1, 8'd9));
    offer(packet(8'd250, 8'd255, 8'd255, 8'd9));
    offer(packet(8'd0, 8'd0, 8'd255, 8'd255));
    settle();
    apb_write(ADDR_LIMIT, 32'd0);
    offer(packet(8'd0, 8'd0, 8'd255, 8'd9));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 7) pace <= PACE_HOLD;
      else begin
        case (p % 4)
          0:       pace <= PACE_FREE;
          1:       pace <= PACE_SEND;
          2:       pace <= PACE_RECV;
          default: pace <= PACE_BOTH;
        endcase
      end
      node_id = pick_own(p);
      apb_write(ADDR_OWN_ID, 32'(node_id));
      apb_write(ADDR_LIMIT, 32'(pick_limit(p)));
      repeat (PHASE_ITEMS) offer(rand_item(node_id));
      settle();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d items in %0d settings; %0d decisions checked, %0d forwarded.",
             sent, PHASES + 5, checked, forwarded);
    $display("Neighbour table %s by the end.", table_full ? "filled" : "not filled");
    if (fail_count == 0) begin
      $display("[greedy_geo_forwarder] OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[greedy_geo_forwarder] ERROR");
    end
    $finish;
  end

endmodule
